// ----- src/cfdp_tlv_pkg.sv -----
package cfdp_tlv_pkg;

    localparam int ID_MAX_OCTETS = 8;
    localparam int OUT_DATA_W    = 112;

    // TLV type codes
    localparam logic [7:0] T_FS_REQ  = 8'h00;
    localparam logic [7:0] T_FS_RESP = 8'h01;
    localparam logic [7:0] T_FAULT   = 8'h04;
    localparam logic [7:0] T_ENTITY  = 8'h06;

    // octet roles
    localparam logic [3:0] ROLE_TYPE    = 4'd0;
    localparam logic [3:0] ROLE_LENGTH  = 4'd1;
    localparam logic [3:0] ROLE_ACTION  = 4'd2;
    localparam logic [3:0] ROLE_NAMELEN = 4'd3;
    localparam logic [3:0] ROLE_NAME    = 4'd4;
    localparam logic [3:0] ROLE_MSGLEN  = 4'd5;
    localparam logic [3:0] ROLE_MSG     = 4'd6;
    localparam logic [3:0] ROLE_ID      = 4'd7;
    localparam logic [3:0] ROLE_FAULT   = 4'd8;
    localparam logic [3:0] ROLE_OTHER   = 4'd9;
    localparam logic [3:0] ROLE_EXCESS  = 4'd10;

    // error codes
    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_TRUNC   = 3'd1;
    localparam logic [2:0] ERR_BAD_LEN = 3'd2;
    localparam logic [2:0] ERR_UNDEF   = 3'd3;
    localparam logic [2:0] ERR_LV      = 3'd4;

    localparam logic [3:0] ACTION_MAX    = 4'd8;
    localparam logic [3:0] ACTION_2NAME_LO = 4'd2;
    localparam logic [3:0] ACTION_2NAME_HI = 4'd4;
    localparam logic [3:0] FCOND_MIN     = 4'd1;
    localparam logic [3:0] FCOND_MAX     = 4'd11;
    localparam logic [3:0] FHAND_MIN     = 4'd1;
    localparam logic [3:0] FHAND_MAX     = 4'd4;

    typedef enum logic [8:0] {
        PH_TYPE   = 9'b000000001,
        PH_LEN    = 9'b000000010,
        PH_ID     = 9'b000000100,
        PH_FAULT  = 9'b000001000,
        PH_ACTION = 9'b000010000,
        PH_LVLEN  = 9'b000100000,
        PH_LVBODY = 9'b001000000,
        PH_OTHER  = 9'b010000000,
        PH_EXCESS = 9'b100000000
    } phase_t;

    typedef enum logic [3:0] {
        LV_FIRST  = 4'b0001,
        LV_SECOND = 4'b0010,
        LV_MSG    = 4'b0100,
        LV_DONE   = 4'b1000
    } lv_stage_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  type_held;
        logic [7:0]  length_held;
        logic [7:0]  value_left;
        logic [7:0]  lv_left;
        lv_stage_t   lv_stage;
        logic        second_needed;
        logic [2:0]  error_held;
        logic [63:0] id_acc;
        logic [3:0]  action_held;
        logic [3:0]  status_held;
    } parse_state_t;

    typedef struct packed {
        logic [3:0]  byte_role;
        logic [7:0]  octet;
        logic [7:0]  tlv_type;
        logic [7:0]  tlv_length;
        logic [3:0]  fs_action;
        logic [3:0]  fs_status;
        logic        name_index;
        logic [63:0] ent_ident;
        logic [3:0]  fault_condition;
        logic [3:0]  fault_handler;
        logic        tlv_end;
        logic [2:0]  error_code;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:         PH_TYPE,
        type_held:     8'd0,
        length_held:   8'd0,
        value_left:    8'd0,
        lv_left:       8'd0,
        lv_stage:      LV_FIRST,
        second_needed: 1'b0,
        error_held:    ERR_OK,
        id_acc:        64'd0,
        action_held:   4'd0,
        status_held:   4'd0
    };

    // first error in a TLV sticks
    function automatic logic [2:0] set_err(input logic [2:0] held, input logic [2:0] e);
        return (held == ERR_OK) ? e : held;
    endfunction

endpackage

// ----- src/cfdp_tlv_step.sv -----
module cfdp_tlv_step (
    input  cfdp_tlv_pkg::parse_state_t state_cur,
    input  logic [7:0]                 octet,
    input  logic                       last,
    output cfdp_tlv_pkg::parse_state_t state_next,
    output cfdp_tlv_pkg::result_t      result
);
    import cfdp_tlv_pkg::*;

    logic [7:0] rem;
    logic       ends;
    logic [3:0] role;
    logic [3:0] fcond;
    logic [3:0] fhand;
    logic       name_idx;
    logic [2:0] err_out;
    logic [7:0] lv_dec;

    function automatic lv_stage_t next_stage(input lv_stage_t st, input logic second,
                                             input logic resp);
        lv_stage_t r;
        unique case (st)
            LV_FIRST:  r = second ? LV_SECOND : (resp ? LV_MSG : LV_DONE);
            LV_SECOND: r = resp ? LV_MSG : LV_DONE;
            default:   r = LV_DONE;
        endcase
        return r;
    endfunction

    assign rem    = state_cur.value_left - 8'd1;
    assign lv_dec = state_cur.lv_left - 8'd1;

    always_comb begin
        state_next = state_cur;
        ends       = 1'b0;
        role       = ROLE_TYPE;
        fcond      = 4'd0;
        fhand      = 4'd0;
        name_idx   = 1'b0;
        err_out    = ERR_OK;

        unique case (state_cur.phase)
            PH_LEN: begin
                role                   = ROLE_LENGTH;
                state_next.length_held = octet;
                state_next.value_left  = octet;
                if (state_cur.type_held == T_ENTITY) begin
                    if (octet < 8'd1 || octet > 8'(ID_MAX_OCTETS)) begin
                        state_next.error_held = set_err(state_cur.error_held, ERR_BAD_LEN);
                        state_next.phase      = PH_EXCESS;
                    end else begin
                        state_next.phase = PH_ID;
                    end
                end else if (state_cur.type_held == T_FAULT) begin
                    if (octet != 8'd1) begin
                        state_next.error_held = set_err(state_cur.error_held, ERR_BAD_LEN);
                        state_next.phase      = PH_EXCESS;
                    end else begin
                        state_next.phase = PH_FAULT;
                    end
                end else if (state_cur.type_held == T_FS_REQ ||
                             state_cur.type_held == T_FS_RESP) begin
                    if (octet == 8'd0)
                        state_next.error_held = set_err(state_cur.error_held, ERR_BAD_LEN);
                    state_next.phase = PH_ACTION;
                end else begin
                    state_next.phase = PH_OTHER;
                end
                ends = (octet == 8'd0);
            end
            PH_ID: begin
                role                  = ROLE_ID;
                state_next.id_acc     = {state_cur.id_acc[55:0], octet};
                state_next.value_left = rem;
                ends                  = (rem == 8'd0);
            end
            PH_FAULT: begin
                role  = ROLE_FAULT;
                fcond = octet[7:4];
                fhand = octet[3:0];
                if (fcond < FCOND_MIN || fcond > FCOND_MAX ||
                    fhand < FHAND_MIN || fhand > FHAND_MAX)
                    state_next.error_held = set_err(state_cur.error_held, ERR_UNDEF);
                state_next.value_left = rem;
                ends                  = (rem == 8'd0);
            end
            PH_ACTION: begin
                role                   = ROLE_ACTION;
                state_next.action_held = octet[7:4];
                if (state_cur.type_held == T_FS_RESP)
                    state_next.status_held = octet[3:0];
                state_next.second_needed = (octet[7:4] >= ACTION_2NAME_LO &&
                                            octet[7:4] <= ACTION_2NAME_HI);
                state_next.lv_stage   = LV_FIRST;
                state_next.value_left = rem;
                ends                  = (rem == 8'd0);
                if (octet[7:4] > ACTION_MAX) begin
                    state_next.error_held = set_err(state_cur.error_held, ERR_UNDEF);
                    state_next.phase      = PH_EXCESS;
                end else begin
                    state_next.phase = PH_LVLEN;
                end
            end
            PH_LVLEN: begin
                role     = (state_cur.lv_stage == LV_MSG) ? ROLE_MSGLEN : ROLE_NAMELEN;
                name_idx = (state_cur.lv_stage == LV_SECOND);
                state_next.value_left = rem;
                ends                  = (rem == 8'd0);
                state_next.lv_left    = octet;
                if (octet > rem) begin
                    state_next.error_held = set_err(state_cur.error_held, ERR_LV);
                    state_next.phase      = PH_EXCESS;
                end else if (octet == 8'd0) begin
                    state_next.lv_stage = next_stage(state_cur.lv_stage,
                                                     state_cur.second_needed,
                                                     state_cur.type_held == T_FS_RESP);
                    if (state_next.lv_stage == LV_DONE) begin
                        if (rem != 8'd0) begin
                            state_next.error_held = set_err(state_cur.error_held, ERR_LV);
                            state_next.phase      = PH_EXCESS;
                        end
                    end else begin
                        state_next.phase = PH_LVLEN;
                    end
                end else begin
                    state_next.phase = PH_LVBODY;
                end
            end
            PH_LVBODY: begin
                role     = (state_cur.lv_stage == LV_MSG) ? ROLE_MSG : ROLE_NAME;
                name_idx = (state_cur.lv_stage == LV_SECOND);
                state_next.value_left = rem;
                ends                  = (rem == 8'd0);
                state_next.lv_left    = lv_dec;
                if (lv_dec == 8'd0) begin
                    state_next.lv_stage = next_stage(state_cur.lv_stage,
                                                     state_cur.second_needed,
                                                     state_cur.type_held == T_FS_RESP);
                    if (state_next.lv_stage == LV_DONE) begin
                        if (rem != 8'd0) begin
                            state_next.error_held = set_err(state_cur.error_held, ERR_LV);
                            state_next.phase      = PH_EXCESS;
                        end
                    end else begin
                        state_next.phase = PH_LVLEN;
                    end
                end
            end
            PH_OTHER: begin
                role                  = ROLE_OTHER;
                state_next.value_left = rem;
                ends                  = (rem == 8'd0);
            end
            PH_EXCESS: begin
                role                  = ROLE_EXCESS;
                state_next.value_left = rem;
                ends                  = (rem == 8'd0);
            end
            default: begin
                // type octet opens a new TLV
                state_next           = STATE_RESET;
                state_next.type_held = octet;
                state_next.phase     = PH_LEN;
            end
        endcase

        // filestore value ran out before every expected LV was seen
        if (ends && role >= ROLE_ACTION && role <= ROLE_MSG &&
            state_next.lv_stage != LV_DONE)
            state_next.error_held = set_err(state_next.error_held, ERR_LV);

        if (ends) begin
            err_out          = state_next.error_held;
            state_next.phase = PH_TYPE;
        end else if (last) begin
            err_out          = ERR_TRUNC;
            state_next.phase = PH_TYPE;
        end

        result.byte_role       = role;
        result.octet           = octet;
        result.tlv_type        = state_next.type_held;
        result.tlv_length      = state_next.length_held;
        result.fs_action       = state_next.action_held;
        result.fs_status       = state_next.status_held;
        result.name_index      = name_idx;
        result.ent_ident       = state_next.id_acc;
        result.fault_condition = fcond;
        result.fault_handler   = fhand;
        result.tlv_end         = ends | last;
        result.error_code      = err_out;
    end

endmodule

// ----- src/cfdp_tlv_stream_parser.sv -----
// Datapath: a transaction accepted into the input register passes through the parse logic
// into the result register, which drives m_tvalid.
// Throughput: one octet per cycle; s_tready drops only when both registers are full
// and m_tready is low.
// Reset: synchronous on aresetn low; clears both valid flags and the parse state,
// after which the parser expects a type octet.
module cfdp_tlv_stream_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // octet_in
    input  logic         s_tlast,   // buffer_last
    output logic         m_tvalid,
    input  logic         m_tready,
    // octet_out[7:0], tlv_type[15:8], tlv_length[23:16], fs_action[27:24],
    // fs_status[31:28], name_index[32], ent_ident[96:33], fault_condition[100:97],
    // fault_handler[104:101], error_code[107:105], zero pad[111:108]
    output logic [cfdp_tlv_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [3:0]   m_tuser,   // byte_role
    output logic         m_tlast    // tlv_end
);
    import cfdp_tlv_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_octet_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    result_t      out_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_next;
    logic         advance;
    logic         fire;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    cfdp_tlv_step u_step (
        .state_cur  (state_reg),
        .octet      (in_octet_reg),
        .last       (in_last_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_octet_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end
        if (fire)
            out_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.byte_role;
    assign m_tlast  = out_reg.tlv_end;
    assign m_tdata  = {4'd0, out_reg.error_code, out_reg.fault_handler,
                       out_reg.fault_condition, out_reg.ent_ident, out_reg.name_index,
                       out_reg.fs_status, out_reg.fs_action, out_reg.tlv_length,
                       out_reg.tlv_type, out_reg.octet};

`ifndef SYNTHESIS
    // error code only shows on the octet that closes a TLV
    a_err_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[107:105] == ERR_OK)
        else $error("error code set on an octet without tlv_end");

    // fault nibbles are zero except on the fault octet
    a_fault_nibbles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ROLE_FAULT |-> m_tdata[104:97] == 8'd0)
        else $error("fault nibbles set outside the fault octet");

    // the type octet carries a zero length
    a_type_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ROLE_TYPE |-> m_tdata[23:16] == 8'd0)
        else $error("nonzero length on a type octet");

    // input side stalls only with both stages full and the output blocked
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a full pipeline");
`endif

endmodule
